// ===== hw/rtl/cfcs_pkg.sv =====
// Shared constants for the framed channel sender with CRC-16 (Modbus form).
// No dependencies; imported by the CRC step unit and the top level.
package cfcs_pkg;

    // Frame geometry: four 16-bit channels as eight data bytes, then two CRC bytes.
    localparam int unsigned CHAN_W      = 16;
    localparam int unsigned NUM_CHANS   = 4;
    localparam int unsigned IN_W        = CHAN_W * NUM_CHANS;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned DATA_BYTES  = IN_W / BYTE_W;
    localparam int unsigned FRAME_BYTES = DATA_BYTES + 2;
    localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
    localparam int unsigned SEL_W       = $clog2(DATA_BYTES);

    // Byte positions that carry the checksum.
    localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(DATA_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(DATA_BYTES + 1);

    // CRC-16 parameters: reflected polynomial, all-ones start, no final inversion.
    localparam int unsigned      CRC_W    = 16;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    typedef logic [CRC_W-1:0]  t_crc;
    typedef logic [BYTE_W-1:0] t_byte;

endpackage

// ===== hw/rtl/cfcs_crc_step.sv =====
// One-byte update of the reflected CRC-16: eight shift/xor steps on a 16-bit value.
// Depends on cfcs_pkg for the polynomial and types.
module cfcs_crc_step (
    input  cfcs_pkg::t_crc  i_crc,
    input  cfcs_pkg::t_byte i_data,
    output cfcs_pkg::t_crc  o_crc
);
    import cfcs_pkg::*;

    // Fold the byte into the low end, then shift out eight bits LSB first.
    always_comb begin
        t_crc acc;
        acc = i_crc ^ {{(CRC_W - BYTE_W){1'b0}}, i_data};
        for (int b = 0; b < BYTE_W; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        o_crc = acc;
    end

endmodule

// ===== hw/rtl/crc16_framed_channel_sender.sv =====
// Top level of the framed channel sender: frame register, byte sequencer,
// running CRC and output register. Depends on cfcs_pkg and cfcs_crc_step.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         64     chan_a[15:0], chan_b[31:16], chan_c[47:32], chan_d[63:48]
//  m_axis    out        8      frame_byte in tdata, last_byte in tlast
//
// Each accepted item produces ten output transfers, one per cycle when the
// sink is ready, paced by the byte sequencer that walks the frame register.
// The next item is accepted in the same cycle the tenth byte moves to the
// output register, so frames follow without gaps. The CRC is updated
// one byte per cycle when the sink is ready, as data bytes are emitted.
// A stalled sink holds the output register and the sequencer.
// Reset (synchronous, active low) clears the valid flags and the sequencer.
module crc16_framed_channel_sender (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: chan_a [15:0], chan_b [31:16], chan_c [47:32], chan_d [63:48]
    input  logic [cfcs_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // tdata: frame_byte [7:0]
    output logic [cfcs_pkg::BYTE_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);
    import cfcs_pkg::*;

    logic [IN_W-1:0]  r_frame;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    t_crc             r_crc;
    logic             r_out_valid;
    t_byte            r_out_byte;
    logic             r_out_last;

    logic             advance;
    logic             at_last;
    logic             in_xfer;
    t_byte            data_byte;
    t_byte            sel_byte;
    t_crc             crc_next;

    // The sequencer moves one byte whenever the output register is free.
    assign advance         = r_busy && (!r_out_valid || i_m_axis_tready);
    assign at_last         = (r_idx == IDX_CRC_HI);
    assign o_s_axis_tready = !r_busy || (advance && at_last);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Data byte at the current position, low byte of channel a first.
    assign data_byte = r_frame[r_idx[SEL_W-1:0] * BYTE_W +: BYTE_W];

    cfcs_crc_step u_crc_step (
        .i_crc  (r_crc),
        .i_data (data_byte),
        .o_crc  (crc_next)
    );

    // Choose a data byte or one half of the finished checksum.
    always_comb begin
        if (r_idx == IDX_CRC_LO) begin
            sel_byte = r_crc[BYTE_W-1:0];
        end else if (r_idx == IDX_CRC_HI) begin
            sel_byte = r_crc[CRC_W-1:BYTE_W];
        end else begin
            sel_byte = data_byte;
        end
    end

    // Frame register, sequencer and running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_crc  <= CRC_INIT;
        end else if (in_xfer) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_crc  <= CRC_INIT;
        end else if (advance) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + IDX_W'(1);
            if (r_idx < IDX_CRC_LO) begin
                r_crc <= crc_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_frame <= i_s_axis_tdata;
        end
    end

    // Output register: loads on each advance, empties on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= sel_byte;
            r_out_last <= at_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

    // A new frame always starts at byte zero with a fresh CRC.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_busy && r_idx == '0 && r_crc == CRC_INIT))
        else $error("frame did not start cleanly");

    // The sequencer never runs past the last frame byte.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= IDX_CRC_HI))
        else $error("byte index out of range");

    // An item is taken mid-frame only as the tenth byte leaves.
    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_busy) |-> (advance && at_last))
        else $error("item accepted in the middle of a frame");

    // The tenth byte reaches the output flagged as last.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && at_last) |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("last byte not flagged");

endmodule

// ===== verif/crc16_framed_channel_sender_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for crc16_framed_channel_sender: streams channel sets in,
// predicts every frame byte with its own CRC-16 (Modbus form), and checks the output stream.
// Depends on cfcs_pkg and the crc16_framed_channel_sender RTL.
module crc16_framed_channel_sender_test;
    import cfcs_pkg::*;

    localparam int unsigned DIRECTED_COUNT = 15;
    localparam int unsigned RANDOM_COUNT   = 315;
    // The long sink stall starts once this many frame bytes have been checked.
    localparam int unsigned HOLDOFF_AT     = 300;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES   = 30;
    localparam t_crc        MODBUS_INIT    = 16'hFFFF;
    localparam t_crc        MODBUS_POLY    = 16'hA001;

    // One frame byte as it should appear on the output stream.
    typedef struct packed {
        t_byte value;
        logic  last;
    } t_frame_byte;

    logic            i_clk;
    logic            i_rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    // tdata: chan_a [15:0], chan_b [31:16], chan_c [47:32], chan_d [63:48]
    logic [IN_W-1:0] s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    // tdata: frame_byte [7:0]
    t_byte           m_axis_tdata;
    logic            m_axis_tlast;

    t_frame_byte     pending_bytes[$];
    int unsigned     mismatches;
    int unsigned     bytes_checked;

    // Directed channel sets, written as chan_d_chan_c_chan_b_chan_a.
    // Every frame is checked against the predictor below.
    logic [IN_W-1:0] directed_frames [DIRECTED_COUNT] = '{
        64'h0000_0000_0000_0000,  // all zero
        64'hFFFF_FFFF_FFFF_FFFF,  // all ones
        64'h0000_0000_0000_FFFF,  // only chan_a set
        64'h0000_0000_FFFF_0000,  // only chan_b set
        64'h0000_FFFF_0000_0000,  // only chan_c set
        64'hFFFF_0000_0000_0000,  // only chan_d set
        64'h0001_0001_0001_0001,  // lowest bit of each channel
        64'h8000_8000_8000_8000,  // highest bit of each channel
        64'h00FF_00FF_00FF_00FF,  // low bytes only
        64'hFF00_FF00_FF00_FF00,  // high bytes only
        64'h0807_0605_0403_0201,  // distinct bytes show the byte order
        64'hAAAA_5555_AAAA_5555,
        64'h5555_AAAA_5555_AAAA,
        64'h7FFF_8000_FFFE_0001,
        64'hFFFF_FFFF_FFFF_FFFE
    };

    crc16_framed_channel_sender dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    // CRC-16 over the eight payload bytes, chan_a low byte first.
    function automatic t_crc modbus_crc(input logic [IN_W-1:0] payload);
        t_crc crc;
        crc = MODBUS_INIT;
        for (int k = 0; k < DATA_BYTES; k++) begin
            crc = crc ^ {8'h00, payload[8*k +: 8]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ MODBUS_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // Appends the ten bytes that one accepted channel set must produce.
    task automatic predict_frame(input logic [IN_W-1:0] payload);
        t_crc        crc;
        t_frame_byte fb;
        crc = modbus_crc(payload);
        for (int k = 0; k < DATA_BYTES; k++) begin
            fb.value = payload[8*k +: 8];
            fb.last  = 1'b0;
            pending_bytes.push_back(fb);
        end
        fb.value = crc[7:0];
        fb.last  = 1'b0;
        pending_bytes.push_back(fb);
        fb.value = crc[15:8];
        fb.last  = 1'b1;
        pending_bytes.push_back(fb);
    endtask

    // Sender wait before an item; some stretches run back to back.
    function automatic int unsigned sender_gap(input int unsigned idx);
        if ((idx / 32) % 3 == 2) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // One random channel value, biased toward the edges of the range.
    function automatic logic [15:0] random_channel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001 << $urandom_range(0, 15);
            3: return ~(16'h0001 << $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one channel set and waits for its transfer; valid stays high across
    // back-to-back items.
    task automatic send_channels(input logic [IN_W-1:0] payload, input int unsigned gap);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame(payload);
    endtask

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Guard against a hung block.
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Reset, stimulus and end of run.
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        mismatches    = 0;
        bytes_checked = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_channels(directed_frames[i], sender_gap(i));
        end
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            send_channels({random_channel(), random_channel(), random_channel(),
                           random_channel()}, sender_gap(DIRECTED_COUNT + i));
        end
        s_axis_tvalid <= 1'b0;

        // Let every predicted byte arrive, then watch for stray output.
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Sink: random stalls per byte, stall-free stretches, and one long hold-off
    // that backs the block up while the sender keeps offering items.
    initial begin : frame_sink
        int unsigned stall;
        t_frame_byte want;
        m_axis_tready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (bytes_checked == HOLDOFF_AT) begin
                stall = HOLDOFF_CYCLES;
            end else if ((bytes_checked / 120) % 3 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 19);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);

            // Compare the transfer with the oldest predicted byte.
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected output transfer: tdata=%h tlast=%b",
                             m_axis_tdata, m_axis_tlast);
                end
            end else begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"Byte %0d mismatch: expected tdata=%h tlast=%b, ",
                                  "got tdata=%h tlast=%b"},
                                 bytes_checked, want.value, want.last,
                                 m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

endmodule

// ===== files.f =====
hw/rtl/cfcs_pkg.sv
hw/rtl/cfcs_crc_step.sv
hw/rtl/crc16_framed_channel_sender.sv
verif/crc16_framed_channel_sender_test.sv
